>>> design/mbe_pkg.sv
// shared constants, types and codes for the escape-time iteration block
// no dependencies; used by mbe_mul_unit and mandelbrot_escape_iteration
package mbe_pkg;

    // fixed-point format of the working coordinates
    localparam int FRAC_BITS   = 28;
    localparam int COORD_WIDTH = 32;

    // port field widths
    localparam int IN_WIDTH        = 31;
    localparam int COUNT_WIDTH     = 8;
    localparam int BOUND_WIDTH     = 31;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 31;

    // product and saturation widths
    localparam int PROD_WIDTH = 2 * COORD_WIDTH;
    localparam int EXT_WIDTH  = (PROD_WIDTH > 64) ? PROD_WIDTH : 64;
    localparam int SQ_WIDTH   = 63;
    localparam int SUM_WIDTH  = 66;

    localparam logic [EXT_WIDTH-1:0] SQ_CAP = EXT_WIDTH'(1) << 62;
    localparam logic [EXT_WIDTH-1:0] XY_CAP = EXT_WIDTH'(1) << 61;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ITER_LIMIT   = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ESCAPE_BOUND = CFG_INDEX_WIDTH'(1);

    // register reset values
    localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET = COUNT_WIDTH'(255);
    localparam logic [BOUND_WIDTH-1:0] BOUND_RESET = BOUND_WIDTH'(1) << (FRAC_BITS + 2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_CROSS,
        ST_UPDATE,
        ST_DONE
    } t_state;

    typedef enum logic {
        MUL_SQUARE,
        MUL_CROSS
    } t_mul_op;

    typedef struct packed {
        t_mul_op                op;
        logic [COORD_WIDTH-1:0] a;
        logic [COORD_WIDTH-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic [SQ_WIDTH-1:0] value;
        logic                inexact;
    } t_mul_res;

endpackage

>>> design/mbe_mul_unit.sv
// shared multiplier: magnitude product, fraction drop and saturation, registered
// depends on mbe_pkg
module mbe_mul_unit (
    input  logic              i_clk,
    input  mbe_pkg::t_mul_req i_req,
    output mbe_pkg::t_mul_res o_res
);

    logic [mbe_pkg::PROD_WIDTH-1:0] w_prod;
    logic [mbe_pkg::EXT_WIDTH-1:0]  w_shift;
    logic [mbe_pkg::EXT_WIDTH-1:0]  w_cap;
    mbe_pkg::t_mul_res              r_res;
    mbe_pkg::t_mul_res              n_res;

    // full product, then drop the fraction bits
    assign w_prod  = mbe_pkg::PROD_WIDTH'(i_req.a) * mbe_pkg::PROD_WIDTH'(i_req.b);
    assign w_shift = mbe_pkg::EXT_WIDTH'(w_prod) >> mbe_pkg::FRAC_BITS;

    // saturate at the cap of the operation
    always_comb begin
        w_cap = (i_req.op == mbe_pkg::MUL_SQUARE) ? mbe_pkg::SQ_CAP : mbe_pkg::XY_CAP;
        if (w_shift > w_cap) begin
            n_res.value = mbe_pkg::SQ_WIDTH'(w_cap);
        end else begin
            n_res.value = mbe_pkg::SQ_WIDTH'(w_shift);
        end
        n_res.inexact = (w_prod[mbe_pkg::FRAC_BITS-1:0] != '0);
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

>>> design/mandelbrot_escape_iteration.sv
// escape-time counter for one point of the complex plane: sequencer and datapath
// depends on mbe_pkg and mbe_mul_unit
//
// channel   direction  handshake                    payload
// input     in         i_valid / o_stall            i_c_real, i_c_imag
// output    out        o_valid / i_stall            o_iter_count, o_green_level, o_blue_level
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// one shared multiplier forms x*x, y*y and x*y in turn, followed by an update step
// a point that escapes after n updates reports a count of n, and one that runs to the
// limit reports the limit; the next point is accepted from the cycle its result appears
// synchronous active-low reset; both configuration registers return to their reset values
// a result waits in the output register while i_stall is high; a new point is
// accepted meanwhile and its result waits in the done state until the register frees
module mandelbrot_escape_iteration (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [mbe_pkg::IN_WIDTH-1:0]    i_c_real,
    input  logic signed [mbe_pkg::IN_WIDTH-1:0]    i_c_imag,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [mbe_pkg::COUNT_WIDTH-1:0]        o_iter_count,
    output logic [mbe_pkg::COUNT_WIDTH-1:0]        o_green_level,
    output logic [mbe_pkg::COUNT_WIDTH-2:0]        o_blue_level,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [mbe_pkg::CFG_INDEX_WIDTH-1:0]    i_cfg_index,
    input  logic [mbe_pkg::CFG_DATA_WIDTH-1:0]     i_cfg_data
);

    localparam logic signed [mbe_pkg::SUM_WIDTH-1:0] CLAMP_HI =
        (mbe_pkg::SUM_WIDTH'(1) << (mbe_pkg::COORD_WIDTH - 1)) - mbe_pkg::SUM_WIDTH'(1);
    localparam logic signed [mbe_pkg::SUM_WIDTH-1:0] CLAMP_LO = -CLAMP_HI - 1;

    function automatic logic [mbe_pkg::COORD_WIDTH-1:0] f_mag(
        input logic signed [mbe_pkg::COORD_WIDTH-1:0] v
    );
        return v[mbe_pkg::COORD_WIDTH-1] ? mbe_pkg::COORD_WIDTH'(-v)
                                         : mbe_pkg::COORD_WIDTH'(v);
    endfunction

    function automatic logic signed [mbe_pkg::COORD_WIDTH-1:0] f_clamp(
        input logic signed [mbe_pkg::SUM_WIDTH-1:0] v
    );
        logic signed [mbe_pkg::SUM_WIDTH-1:0] t;
        t = v;
        if (v > CLAMP_HI) begin
            t = CLAMP_HI;
        end else if (v < CLAMP_LO) begin
            t = CLAMP_LO;
        end
        return t[mbe_pkg::COORD_WIDTH-1:0];
    endfunction

    mbe_pkg::t_state r_state;
    mbe_pkg::t_state n_state;

    logic [mbe_pkg::COUNT_WIDTH-1:0]           r_limit;
    logic [mbe_pkg::BOUND_WIDTH-1:0]           r_bound;
    logic signed [mbe_pkg::IN_WIDTH-1:0]       r_cr;
    logic signed [mbe_pkg::IN_WIDTH-1:0]       r_ci;
    logic signed [mbe_pkg::COORD_WIDTH-1:0]    r_x;
    logic signed [mbe_pkg::COORD_WIDTH-1:0]    n_x;
    logic signed [mbe_pkg::COORD_WIDTH-1:0]    r_y;
    logic signed [mbe_pkg::COORD_WIDTH-1:0]    n_y;
    logic [mbe_pkg::COUNT_WIDTH-1:0]           r_n;
    logic [mbe_pkg::COUNT_WIDTH-1:0]           n_n;
    logic [mbe_pkg::SQ_WIDTH-1:0]              r_x2;
    logic [mbe_pkg::SQ_WIDTH-1:0]              r_y2;
    logic                                      r_out_valid;
    logic                                      n_out_valid;
    logic [mbe_pkg::COUNT_WIDTH-1:0]           r_out_count;
    logic                                      w_load_out;

    logic                                      w_in_accept;
    mbe_pkg::t_mul_req                         w_req;
    mbe_pkg::t_mul_res                         w_res;
    logic [mbe_pkg::SQ_WIDTH:0]                w_r2;
    logic                                      w_escape;
    logic                                      w_neg;
    logic [mbe_pkg::SQ_WIDTH:0]                w_m_adj;
    logic signed [mbe_pkg::SUM_WIDTH-1:0]      w_xy;
    logic signed [mbe_pkg::SUM_WIDTH-1:0]      w_x2_s;
    logic signed [mbe_pkg::SUM_WIDTH-1:0]      w_y2_s;
    logic signed [mbe_pkg::SUM_WIDTH-1:0]      w_cr_s;
    logic signed [mbe_pkg::SUM_WIDTH-1:0]      w_ci_s;
    logic signed [mbe_pkg::SUM_WIDTH-1:0]      w_new_x;
    logic signed [mbe_pkg::SUM_WIDTH-1:0]      w_new_y;

    assign w_in_accept = i_valid && (r_state == mbe_pkg::ST_IDLE);
    assign o_stall     = (r_state != mbe_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // operand selection for the shared multiplier
    always_comb begin
        w_req.op = mbe_pkg::MUL_SQUARE;
        w_req.a  = f_mag(r_x);
        w_req.b  = f_mag(r_x);
        case (r_state)
            mbe_pkg::ST_SQ_Y: begin
                w_req.a = f_mag(r_y);
                w_req.b = f_mag(r_y);
            end
            mbe_pkg::ST_CROSS: begin
                w_req.op = mbe_pkg::MUL_CROSS;
                w_req.b  = f_mag(r_y);
            end
            default: begin
            end
        endcase
    end

    mbe_mul_unit u_mul (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_res (w_res)
    );

    // escape test: x2 held, y2 arriving from the multiplier
    assign w_r2     = {1'b0, r_x2} + {1'b0, w_res.value};
    assign w_escape = (w_r2 >= (mbe_pkg::SQ_WIDTH + 1)'(r_bound));

    // signed cross product, rounded toward minus infinity
    assign w_neg   = r_x[mbe_pkg::COORD_WIDTH-1] ^ r_y[mbe_pkg::COORD_WIDTH-1];
    assign w_m_adj = {1'b0, w_res.value} + (mbe_pkg::SQ_WIDTH + 1)'(w_res.inexact);
    assign w_xy    = w_neg ? -mbe_pkg::SUM_WIDTH'(w_m_adj)
                           : mbe_pkg::SUM_WIDTH'(w_res.value);

    // coordinate update
    assign w_x2_s  = mbe_pkg::SUM_WIDTH'(r_x2);
    assign w_y2_s  = mbe_pkg::SUM_WIDTH'(r_y2);
    assign w_cr_s  = mbe_pkg::SUM_WIDTH'(r_cr);
    assign w_ci_s  = mbe_pkg::SUM_WIDTH'(r_ci);
    assign w_new_x = w_x2_s - w_y2_s + w_cr_s;
    assign w_new_y = w_xy + w_xy + w_ci_s;

    // sequencer: next state and datapath controls
    always_comb begin
        n_state    = r_state;
        n_x        = r_x;
        n_y        = r_y;
        n_n        = r_n;
        w_load_out = 1'b0;
        case (r_state)
            mbe_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = mbe_pkg::ST_SQ_X;
                    n_x     = '0;
                    n_y     = '0;
                    n_n     = '0;
                end
            end
            mbe_pkg::ST_SQ_X: begin
                if (r_n == r_limit) begin
                    n_state = mbe_pkg::ST_DONE;
                end else begin
                    n_state = mbe_pkg::ST_SQ_Y;
                end
            end
            mbe_pkg::ST_SQ_Y: begin
                n_state = mbe_pkg::ST_CROSS;
            end
            mbe_pkg::ST_CROSS: begin
                if (w_escape) begin
                    n_state = mbe_pkg::ST_DONE;
                end else begin
                    n_state = mbe_pkg::ST_UPDATE;
                end
            end
            mbe_pkg::ST_UPDATE: begin
                n_x     = f_clamp(w_new_x);
                n_y     = f_clamp(w_new_y);
                n_n     = r_n + mbe_pkg::COUNT_WIDTH'(1);
                n_state = mbe_pkg::ST_SQ_X;
            end
            mbe_pkg::ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    w_load_out = 1'b1;
                    n_state    = mbe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mbe_pkg::ST_IDLE;
            end
        endcase
    end

    // output register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mbe_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= mbe_pkg::LIMIT_RESET;
            r_bound <= mbe_pkg::BOUND_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                mbe_pkg::CFG_ITER_LIMIT: begin
                    r_limit <= i_cfg_data[mbe_pkg::COUNT_WIDTH-1:0];
                end
                mbe_pkg::CFG_ESCAPE_BOUND: begin
                    r_bound <= i_cfg_data[mbe_pkg::BOUND_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_n <= n_n;
        if (w_in_accept) begin
            r_cr <= i_c_real;
            r_ci <= i_c_imag;
        end
        if (r_state == mbe_pkg::ST_SQ_Y) begin
            r_x2 <= w_res.value;
        end
        if (r_state == mbe_pkg::ST_CROSS) begin
            r_y2 <= w_res.value;
        end
        if (w_load_out) begin
            r_out_count <= r_n;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_iter_count  = r_out_count;
    assign o_green_level = r_out_count;
    assign o_blue_level  = r_out_count[mbe_pkg::COUNT_WIDTH-1:1];

    // a new point starts from zero
    a_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state == mbe_pkg::ST_SQ_X) && (r_n == '0)
                        && (r_x == '0) && (r_y == '0))
        else $error("point did not start from zero");

    // a finished count waits while the output register is held
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mbe_pkg::ST_DONE && r_out_valid && i_stall)
            |=> (r_state == mbe_pkg::ST_DONE) && r_out_valid)
        else $error("result overwrote a waiting transaction");

    // every update advances the count by one and returns to the first square
    a_update_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mbe_pkg::ST_UPDATE)
            |=> (r_state == mbe_pkg::ST_SQ_X)
                && (r_n == mbe_pkg::COUNT_WIDTH'($past(r_n) + 1)))
        else $error("iteration count did not advance");

    // output becomes valid only from the done state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == mbe_pkg::ST_DONE))
        else $error("output valid without a finished point");

endmodule
